FILE: design/lsi_pkg.sv
package lsi_pkg;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;

  typedef enum logic [1:0] {
    KindNone      = 2'd0,
    KindPoint     = 2'd1,
    KindCollinear = 2'd2
  } hit_kind_e;
endpackage

FILE: design/lsi_if.sv
interface lsi_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] seg_start_x;
  logic [W-1:0] seg_start_y;
  logic [W-1:0] seg_end_x;
  logic [W-1:0] seg_end_y;
  logic [W-1:0] line_slope;
  logic [W-1:0] line_offset;
  logic         line_vertical;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  line_slope, line_offset, line_vertical, input ready);
  modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  line_slope, line_offset, line_vertical, output ready);
endinterface

interface lsi_out_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [1:0]   hit_kind;
  logic [W-1:0] hit_x;
  logic [W-1:0] hit_y;

  modport source (output valid, hit_kind, hit_x, hit_y, input ready);
  modport sink   (input valid, hit_kind, hit_x, hit_y, output ready);
endinterface

FILE: design/lsi_div_cell.sv
module lsi_div_cell #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o
);
  logic [DW:0]   trial;
  logic [DW:0]   shifted;
  logic [NW-1:0] num_d;
  logic [DW-1:0] rem_d;

  always_comb begin
    shifted = {rem_i, num_i[NW-1]};
    trial   = shifted - {1'b0, den_i};
    if (!trial[DW]) begin
      rem_d = trial[DW-1:0];
      num_d = {num_i[NW-2:0], 1'b1};
    end else begin
      rem_d = shifted[DW-1:0];
      num_d = {num_i[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      rem_o <= rem_d;
      den_o <= den_i;
    end
  end
endmodule

FILE: design/lsi_divider.sv
// Unsigned restoring divider built as a chain of cells, one quotient bit per cell.
module lsi_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 34,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);
  logic [NW-1:0] num_w [NW+1];
  logic [DW-1:0] rem_w [NW+1];
  logic [DW-1:0] den_w [NW+1];
  logic [TW-1:0] tag_q [NW];
  logic [NW-1:0] vld_q;

  assign num_w[0] = num_i;
  assign rem_w[0] = '0;
  assign den_w[0] = den_i;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    lsi_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num_w[i]),
      .rem_i (rem_w[i]),
      .den_i (den_w[i]),
      .num_o (num_w[i+1]),
      .rem_o (rem_w[i+1]),
      .den_o (den_w[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i] <= (i == 0) ? tag_i : tag_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = num_w[NW];
  assign tag_o   = tag_q[NW-1];
endmodule

FILE: design/line_segment_intersect.sv
// Channel | Dir | Payload
// in_if   | in  | segment end points, slope, offset, vertical flag
// out_if  | out | hit_kind, hit_x, hit_y
// One word is accepted per cycle while the output is not stalled; the x and y
// bit-per-cell divider chains run side by side.
// The pipeline advances whenever its last stage is empty or being taken.
// Reset clears all valid flags; payload registers are not reset.
// A stall at the output freezes every stage, so no word is lost.
module line_segment_intersect #(
  parameter int unsigned COORD_WIDTH = lsi_pkg::CoordWidth,
  parameter int unsigned FRAC_BITS   = lsi_pkg::FracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsi_in_if.sink    in_if,
  lsi_out_if.source out_if
);
  import lsi_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned EW = W + 3;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned TW = W + 2 + 1;
  localparam logic signed [W+2:0] MaxV = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] MinV = -MaxV - 1;

  logic adv;
  logic out_vld_q;
  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = adv;

  function automatic logic signed [W+2:0] sat_ext(input logic signed [2*W-1:0] p);
    logic signed [2*W-1:0] s;
    s = p >>> FRAC_BITS;
    if (p < 0 && p[FRAC_BITS-1:0] != '0) s = s + 1;
    if (s > $signed({{(W+1){1'b0}}, {(W-1){1'b1}}})) return MaxV;
    if (s < -$signed({{(W+1){1'b0}}, {(W-1){1'b1}}}) - 1) return MinV;
    return s[W+2:0];
  endfunction

  // Stage 1: differences and products.
  logic                 s1_v_q, s1_vert_q;
  logic signed [W:0]    s1_dx_q, s1_dy_q;
  logic signed [W-1:0]  s1_x1_q, s1_y1_q, s1_q_q;
  logic signed [2*W-1:0] s1_mx1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_vert_q <= in_if.line_vertical;
      s1_x1_q   <= $signed(in_if.seg_start_x);
      s1_y1_q   <= $signed(in_if.seg_start_y);
      s1_q_q    <= $signed(in_if.line_offset);
      s1_dx_q   <= $signed({in_if.seg_end_x[W-1], in_if.seg_end_x})
                 - $signed({in_if.seg_start_x[W-1], in_if.seg_start_x});
      s1_dy_q   <= $signed({in_if.seg_end_y[W-1], in_if.seg_end_y})
                 - $signed({in_if.seg_start_y[W-1], in_if.seg_start_y});
      s1_mx1_q  <= $signed(in_if.line_slope) * $signed(in_if.seg_start_x);
    end
  end

  // m*dx needs dx; form it in stage 2 from the registered dx and slope.
  logic signed [W-1:0] s1_m_q;
  always_ff @(posedge clk_i) if (adv) s1_m_q <= $signed(in_if.line_slope);

  logic                   s2_vert_q;
  logic signed [W:0]      s2_dx_q, s2_dy_q;
  logic signed [W-1:0]    s2_x1_q, s2_y1_q, s2_q_q;
  logic signed [2*W+1:0]  s2_mdx_q;
  logic signed [W+2:0]    s2_mx1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_vert_q <= s1_vert_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_x1_q   <= s1_x1_q;
      s2_y1_q   <= s1_y1_q;
      s2_q_q    <= s1_q_q;
      s2_mdx_q  <= $signed({s1_m_q[W-1], s1_m_q}) * $signed(s1_dx_q);
      s2_mx1_q  <= sat_ext(s1_mx1_q);
    end
  end

  // Saturate m*dx (W+1 bit operand, wider product).
  function automatic logic signed [W+2:0] sat_wide(input logic signed [2*W+1:0] p);
    logic signed [2*W+1:0] s;
    s = p >>> FRAC_BITS;
    if (p < 0 && p[FRAC_BITS-1:0] != '0) s = s + 1;
    if (s > $signed({{(W+3){1'b0}}, {(W-1){1'b1}}})) return MaxV;
    if (s < -$signed({{(W+3){1'b0}}, {(W-1){1'b1}}}) - 1) return MinV;
    return s[W+2:0];
  endfunction

  // Stage 3: numerator and denominator.
  logic                s3_v_q, s2_v_q;
  logic signed [EW-1:0] s3_num_q, s3_den_q;
  logic signed [W:0]    s3_dx_q, s3_dy_q;
  logic signed [W-1:0]  s3_x1_q, s3_y1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dx_q <= s2_dx_q;
      s3_dy_q <= s2_dy_q;
      s3_x1_q <= s2_x1_q;
      s3_y1_q <= s2_y1_q;
      if (s2_vert_q) begin
        s3_den_q <= EW'(s2_dx_q);
        s3_num_q <= EW'($signed({s2_q_q[W-1], s2_q_q})
                  - $signed({s2_x1_q[W-1], s2_x1_q}));
      end else begin
        s3_den_q <= EW'(s2_dy_q) - EW'(sat_wide(s2_mdx_q));
        s3_num_q <= EW'(s2_mx1_q) + EW'(s2_q_q) - EW'(s2_y1_q);
      end
    end
  end

  // Stage 4: classify and form |num*d| products.
  logic [EW-1:0] mag_num, mag_den;
  logic          accept_u;
  logic [1:0]    kind_w;
  assign mag_num = s3_num_q[EW-1] ? EW'(-s3_num_q) : EW'(s3_num_q);
  assign mag_den = s3_den_q[EW-1] ? EW'(-s3_den_q) : EW'(s3_den_q);
  assign accept_u = (s3_num_q == '0) ||
                    ((s3_num_q[EW-1] == s3_den_q[EW-1]) && mag_num <= mag_den);
  always_comb begin
    if (s3_den_q == '0) kind_w = (s3_num_q == '0) ? KindCollinear : KindNone;
    else if (accept_u) kind_w = KindPoint;
    else kind_w = KindNone;
  end

  logic            s4_v_q;
  logic [PW-1:0]   s4_px_q, s4_py_q;
  logic [EW-1:0]   s4_den_q;
  logic [TW-1:0]   s4_tagx, s4_tagy;
  logic [1:0]      s4_kind_q;
  logic            s4_negx_q, s4_negy_q;
  logic signed [W-1:0] s4_x1_q, s4_y1_q;
  logic [W:0] mdx, mdy;
  assign mdx = s3_dx_q[W] ? (W+1)'(-s3_dx_q) : (W+1)'(s3_dx_q);
  assign mdy = s3_dy_q[W] ? (W+1)'(-s3_dy_q) : (W+1)'(s3_dy_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_px_q   <= PW'(mag_num) * PW'(mdx);
      s4_py_q   <= PW'(mag_num) * PW'(mdy);
      s4_den_q  <= (s3_den_q == '0) ? EW'(1) : mag_den;
      s4_kind_q <= kind_w;
      s4_negx_q <= (s3_num_q[EW-1] ^ s3_dx_q[W] ^ s3_den_q[EW-1])
                   && s3_num_q != '0 && s3_dx_q != '0;
      s4_negy_q <= (s3_num_q[EW-1] ^ s3_dy_q[W] ^ s3_den_q[EW-1])
                   && s3_num_q != '0 && s3_dy_q != '0;
      s4_x1_q   <= s3_x1_q;
      s4_y1_q   <= s3_y1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_if.valid; s2_v_q <= s1_v_q; s3_v_q <= s2_v_q; s4_v_q <= s3_v_q;
    end
  end

  // Tags carry the start coordinate, sign and kind along each divider chain.
  assign s4_tagx = {s4_kind_q[0], s4_negx_q, s4_kind_q[1], s4_x1_q};
  assign s4_tagy = {s4_kind_q[0], s4_negy_q, s4_kind_q[1], s4_y1_q};

  logic            dvx_v, dvy_v;
  logic [PW-1:0]   qx, qy;
  logic [TW-1:0]   tx, ty;

  lsi_divider #(.NW(PW), .DW(EW), .TW(TW)) u_div_x (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s4_v_q), .num_i(s4_px_q),
    .den_i(s4_den_q), .tag_i(s4_tagx), .valid_o(dvx_v), .quot_o(qx), .tag_o(tx)
  );
  lsi_divider #(.NW(PW), .DW(EW), .TW(TW)) u_div_y (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s4_v_q), .num_i(s4_py_q),
    .den_i(s4_den_q), .tag_i(s4_tagy), .valid_o(dvy_v), .quot_o(qy), .tag_o(ty)
  );

  function automatic logic [W-1:0] finish(input logic [PW-1:0] q, input logic [TW-1:0] t);
    logic signed [W+2:0] off, sum;
    off = t[W+1] ? -$signed(q[W+2:0]) : $signed(q[W+2:0]);
    sum = off + (W+3)'($signed(t[W-1:0]));
    if (sum > MaxV) sum = MaxV;
    if (sum < MinV) sum = MinV;
    return t[W+2] ? sum[W-1:0] : '0;
  endfunction

  logic [1:0]   kind_q;
  logic [W-1:0] hx_q, hy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= {tx[W], tx[W+2]};
      hx_q   <= finish(qx, tx);
      hy_q   <= finish(qy, ty);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= dvx_v;
  end

  assign out_if.valid    = out_vld_q;
  assign out_if.hit_kind = kind_q;
  assign out_if.hit_x    = hx_q;
  assign out_if.hit_y    = hy_q;

  a_chains_agree: assert property (@(posedge clk_i) disable iff (!rst_ni) dvx_v == dvy_v)
    else $error("divider chains out of step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(hx_q))
    else $error("result dropped under stall");
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q != KindPoint |-> hx_q == '0 && hy_q == '0)
    else $error("point not zero");
endmodule
